### src/assert_macros.svh
// Assertion macros shared by the rate divider select block
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion with asynchronous active-low reset disable
`define ARSEL_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("arsel assertion failed");

// Implication form: antecedent must be followed by consequent in the next cycle
`define ARSEL_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("arsel next-cycle assertion failed");

`endif

### src/arsel_pkg.sv
// Constants and shared types of the rate divider select block
package arsel_pkg;

  localparam int unsigned ReqW  = 24;
  localparam int unsigned RateW = 16;
  localparam int unsigned ClkW  = 20;
  localparam int unsigned DivW  = 8;
  localparam int unsigned FNumW = 28;
  localparam int unsigned FDenW = 25;

  localparam logic [RateW-1:0] RateMin     = 16'd4000;
  localparam logic [RateW-1:0] RateMax     = 16'd48000;
  localparam logic [RateW-1:0] LegacySplit = 16'd22000;

  localparam logic [ClkW-1:0] ClkPreciseA = 20'd793800;
  localparam logic [ClkW-1:0] ClkPreciseB = 20'd768000;
  localparam logic [ClkW-1:0] ClkLegacyHi = 20'd795444;
  localparam logic [ClkW-1:0] ClkLegacyLo = 20'd397722;

  // 7160000 * 20 over 8 * 82 * rate
  localparam logic [FNumW-1:0] FilterNum = 28'd143200000;
  localparam logic [9:0]       FilterMul = 10'd656;

  localparam logic [DivW-1:0] CodeBaseLo = 8'd128;

  // Pipeline control handed to each divider stage chain
  typedef struct packed {
    logic en;   // global advance
    logic vld;  // item enters this cycle
  } pipe_ctl_t;

endpackage

### src/audio_rate_divider_select.sv
// Top level of the sample rate divider select pipeline
// Each requested rate is clamped to 4000..48000 Hz and turned into the achieved rate,
// the sample clock divider byte and the filter divider byte. The block is a fully
// pipelined datapath: one transaction enters every cycle unless the output stalls,
// and passes the input register, 8 stages of the rounded divider, 16 stages of the
// rate divider, a select and a multiply stage, 8 stages of the filter divider and the
// output register; each divider stage resolves one quotient bit. A stall on the master
// side freezes the whole pipeline. The mode register is written through cfg_valid_i /
// cfg_data_i and must be changed only while no transaction is in flight.
`include "assert_macros.svh"

module audio_rate_divider_select (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [0:0]  cfg_data_i,    // [0] precise_rate_mode
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,       // [23:0] requested_rate
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata        // [15:0] actual_rate, [23:16] sample_divider_byte,
                                     // [31:24] filter_divider_byte
);

  localparam int unsigned RateW = arsel_pkg::RateW;
  localparam int unsigned ClkW  = arsel_pkg::ClkW;
  localparam int unsigned DivW  = arsel_pkg::DivW;

  logic mode_q;
  logic pipe_en;
  arsel_pkg::pipe_ctl_t ctl1, ctl2, ctl3;

  // mode register
  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= 1'b0;
    end else if (cfg_valid_i) begin
      mode_q <= cfg_data_i[0];
    end
  end

  // whole pipeline advances unless the output is held
  assign pipe_en  = !m_tvalid || m_tready;
  assign s_tready = pipe_en;

  // input register
  logic                       s0_vld_q;
  logic [arsel_pkg::ReqW-1:0] s0_req_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_vld_q <= 1'b0;
    end else if (pipe_en) begin
      s0_vld_q <= s_tvalid;
    end
  end
  always_ff @(posedge clk_i) begin
    if (pipe_en) s0_req_q <= s_tdata;
  end

  // clamp and rounded numerators
  logic [RateW-1:0] rate;
  logic             hi_rng;
  logic [ClkW-1:0]  clk_a;
  logic [ClkW-1:0]  num_a, num_b;
  always_comb begin
    if (s0_req_q < arsel_pkg::ReqW'(arsel_pkg::RateMin)) rate = arsel_pkg::RateMin;
    else if (s0_req_q > arsel_pkg::ReqW'(arsel_pkg::RateMax)) rate = arsel_pkg::RateMax;
    else rate = s0_req_q[RateW-1:0];
    hi_rng = (rate > arsel_pkg::LegacySplit);
    if (mode_q) clk_a = arsel_pkg::ClkPreciseA;
    else if (hi_rng) clk_a = arsel_pkg::ClkLegacyHi;
    else clk_a = arsel_pkg::ClkLegacyLo;
    num_a = clk_a + ClkW'(rate >> 1);
    num_b = arsel_pkg::ClkPreciseB + ClkW'(rate >> 1);
  end

  assign ctl1 = '{en: pipe_en, vld: s0_vld_q};

  // divider selection: clock / rate, rounded
  logic                v1a, v1b;
  logic [DivW-1:0]     d_a, d_b;
  logic [ClkW:0]       side1a;
  logic [RateW:0]      side1b;
  arsel_div #(.NW(ClkW), .DW(RateW), .QW(DivW), .SW(ClkW + 1)) u_div_rnd_a (
    .clk_i, .rst_ni, .ctl_i(ctl1), .num_i(num_a), .den_i(rate),
    .side_i({hi_rng & ~mode_q, clk_a}), .vld_o(v1a), .quo_o(d_a), .side_o(side1a)
  );
  arsel_div #(.NW(ClkW), .DW(RateW), .QW(DivW), .SW(RateW + 1)) u_div_rnd_b (
    .clk_i, .rst_ni, .ctl_i(ctl1), .num_i(num_b), .den_i(rate),
    .side_i({mode_q, rate}), .vld_o(v1b), .quo_o(d_b), .side_o(side1b)
  );

  // divider codes, low 8 bits
  logic [DivW-1:0] code_a, code_b;
  assign code_a = side1a[ClkW] ? (DivW'(0) - d_a) : (arsel_pkg::CodeBaseLo - d_a);
  assign code_b = DivW'(0) - d_b;

  assign ctl2 = '{en: pipe_en, vld: v1a & v1b};

  // achieved rate: clock / divider
  logic                     v2a, v2b;
  logic [RateW-1:0]         r_a, r_b;
  logic [DivW-1:0]          side2a;
  logic [DivW+RateW:0]      side2b;
  arsel_div #(.NW(ClkW), .DW(DivW), .QW(RateW), .SW(DivW)) u_div_rate_a (
    .clk_i, .rst_ni, .ctl_i(ctl2), .num_i(side1a[ClkW-1:0]), .den_i(d_a),
    .side_i(code_a), .vld_o(v2a), .quo_o(r_a), .side_o(side2a)
  );
  arsel_div #(.NW(ClkW), .DW(DivW), .QW(RateW), .SW(DivW + RateW + 1)) u_div_rate_b (
    .clk_i, .rst_ni, .ctl_i(ctl2), .num_i(arsel_pkg::ClkPreciseB), .den_i(d_b),
    .side_i({code_b, side1b}), .vld_o(v2b), .quo_o(r_b), .side_o(side2b)
  );

  // pick the closer candidate; ties go to candidate b, legacy mode always takes candidate a
  logic [RateW-1:0] req2, diff_a, diff_b;
  logic             sel_a;
  always_comb begin
    req2   = side2b[RateW-1:0];
    diff_a = (r_a > req2) ? (r_a - req2) : (req2 - r_a);
    diff_b = (r_b > req2) ? (r_b - req2) : (req2 - r_b);
    sel_a  = !side2b[RateW] || (diff_a < diff_b);
  end

  logic             s2_vld_q;
  logic [RateW-1:0] s2_rate_q;
  logic [DivW-1:0]  s2_code_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_vld_q <= 1'b0;
    end else if (pipe_en) begin
      s2_vld_q <= v2a & v2b;
    end
  end
  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      s2_rate_q <= sel_a ? r_a : r_b;
      s2_code_q <= sel_a ? side2a : side2b[DivW+RateW:RateW+1];
    end
  end

  // filter divisor: 656 * rate
  logic                        s3_vld_q;
  logic [RateW-1:0]            s3_rate_q;
  logic [DivW-1:0]             s3_code_q;
  logic [arsel_pkg::FDenW-1:0] s3_den_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_vld_q <= 1'b0;
    end else if (pipe_en) begin
      s3_vld_q <= s2_vld_q;
    end
  end
  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      s3_rate_q <= s2_rate_q;
      s3_code_q <= s2_code_q;
      s3_den_q  <= arsel_pkg::FDenW'(s2_rate_q) * arsel_pkg::FDenW'(arsel_pkg::FilterMul);
    end
  end

  assign ctl3 = '{en: pipe_en, vld: s3_vld_q};

  // filter quotient
  logic                  v3;
  logic [DivW-1:0]       fq;
  logic [DivW+RateW-1:0] side3;
  arsel_div #(.NW(arsel_pkg::FNumW), .DW(arsel_pkg::FDenW), .QW(DivW),
              .SW(DivW + RateW)) u_div_filt (
    .clk_i, .rst_ni, .ctl_i(ctl3), .num_i(arsel_pkg::FilterNum), .den_i(s3_den_q),
    .side_i({s3_code_q, s3_rate_q}), .vld_o(v3), .quo_o(fq), .side_o(side3)
  );

  // output register
  logic        out_vld_q;
  logic [31:0] out_data_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (pipe_en) begin
      out_vld_q <= v3;
    end
  end
  always_ff @(posedge clk_i) begin
    if (pipe_en) out_data_q <= {DivW'(0) - fq, side3};
  end

  assign m_tvalid = out_vld_q;
  assign m_tdata  = out_data_q;

  // checks
  `ARSEL_ASSERT_NEXT(a_stall_holds_input, clk_i, rst_ni, !pipe_en, $stable(s0_vld_q))
  `ARSEL_ASSERT(a_rate_range, clk_i, rst_ni,
    m_tvalid |-> (m_tdata[15:0] >= 16'd3900 && m_tdata[15:0] <= 16'd49800))
  `ARSEL_ASSERT(a_filter_range, clk_i, rst_ni,
    m_tvalid |-> (m_tdata[31:24] >= 8'd200 && m_tdata[31:24] <= 8'd252))

endmodule

### src/arsel_div.sv
// Pipelined restoring divider, one quotient bit per register stage
module arsel_div #(
  parameter int unsigned NW = 20,
  parameter int unsigned DW = 16,
  parameter int unsigned QW = 8,
  parameter int unsigned SW = 1
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  arsel_pkg::pipe_ctl_t ctl_i,
  input  logic [NW-1:0]      num_i,
  input  logic [DW-1:0]      den_i,
  input  logic [SW-1:0]      side_i,
  output logic               vld_o,
  output logic [QW-1:0]      quo_o,
  output logic [SW-1:0]      side_o
);

  localparam int unsigned CW = NW + DW + QW;

  logic [QW-1:0] vld_q;
  logic [NW-1:0] rem_q  [QW];
  logic [DW-1:0] den_q  [QW];
  logic [QW-1:0] quo_q  [QW];
  logic [SW-1:0] side_q [QW];

  for (genvar k = 0; k < QW; k++) begin : g_stage
    localparam int unsigned Bit = QW - 1 - k;
    logic          vld_in;
    logic [NW-1:0] rem_in;
    logic [DW-1:0] den_in;
    logic [QW-1:0] quo_in;
    logic [SW-1:0] side_in;
    logic [CW-1:0] rem_x;
    logic [CW-1:0] sub_x;
    logic          take;
    logic [NW-1:0] rem_d;
    logic [QW-1:0] quo_d;

    if (k == 0) begin : g_first
      assign vld_in  = ctl_i.vld;
      assign rem_in  = num_i;
      assign den_in  = den_i;
      assign quo_in  = '0;
      assign side_in = side_i;
    end else begin : g_next
      assign vld_in  = vld_q[k-1];
      assign rem_in  = rem_q[k-1];
      assign den_in  = den_q[k-1];
      assign quo_in  = quo_q[k-1];
      assign side_in = side_q[k-1];
    end

    // trial subtract of the shifted divisor
    always_comb begin
      rem_x = CW'(rem_in);
      sub_x = CW'(den_in) << Bit;
      take  = (rem_x >= sub_x);
      rem_d = take ? NW'(rem_x - sub_x) : rem_in;
      quo_d = take ? (quo_in | (QW'(1) << Bit)) : quo_in;
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else if (ctl_i.en) begin
        vld_q[k] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (ctl_i.en) begin
        rem_q[k]  <= rem_d;
        den_q[k]  <= den_in;
        quo_q[k]  <= quo_d;
        side_q[k] <= side_in;
      end
    end
  end

  assign vld_o  = vld_q[QW-1];
  assign quo_o  = quo_q[QW-1];
  assign side_o = side_q[QW-1];

endmodule

### bench/tb_audio_rate_divider_select.sv
// Testbench for the sample rate divider select block: directed and random rates, scoreboard
module tb_audio_rate_divider_select;

  typedef struct packed {
    logic [7:0]  filt;
    logic [7:0]  code;
    logic [15:0] rate;
  } rate_result_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [0:0]  cfg_data_i = 1'b0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [23:0] s_tdata = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;

  audio_rate_divider_select uut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .cfg_valid_i(cfg_valid_i), .cfg_ready_o(cfg_ready_o), .cfg_data_i(cfg_data_i),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  logic          precise_mode;
  logic [23:0]   pending_rates[$];
  rate_result_t  expected_results[$];
  int            mismatches = 0;
  int            idle_cycles = 0;
  bit            stall_hold = 1'b0;
  bit            send_pause = 1'b0;

  function automatic logic [31:0] rdiv(logic [31:0] clk, logic [31:0] r);
    return (clk + r / 2) / r;
  endfunction

  function automatic logic [31:0] dist32(logic [31:0] a, logic [31:0] b);
    return (a > b) ? a - b : b - a;
  endfunction

  // Divider selection for one clamped request
  function automatic rate_result_t pick_divider(logic [23:0] req, logic mode);
    rate_result_t res;
    logic [31:0] r, d0, r0, d1, r1, d, code, filt;
    r = 32'(req);
    if (r < 4000) r = 4000;
    else if (r > 48000) r = 48000;
    if (mode) begin
      d0 = rdiv(793800, r); r0 = 793800 / d0;
      d1 = rdiv(768000, r); r1 = 768000 / d1;
      if (dist32(r0, r) < dist32(r1, r)) begin
        code = 128 - d0; r = r0;
      end else begin
        code = 256 - d1; r = r1;
      end
    end else if (r > 22000) begin
      d = rdiv(795444, r); r = 795444 / d; code = 256 - d;
    end else begin
      d = rdiv(397722, r); r = 397722 / d; code = 128 - d;
    end
    filt = 256 - 143200000 / (656 * r);
    res.rate = r[15:0];
    res.code = code[7:0];
    res.filt = filt[7:0];
    return res;
  endfunction

  // Driver: pops pending rates, random gaps per transaction
  int gap = 0;
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_tvalid && s_tready) begin
        expected_results.push_back(pick_divider(s_tdata, precise_mode));
        gap = $urandom_range(0, 5);
        if (gap == 0 && pending_rates.size() > 0 && !send_pause) begin
          s_tdata <= pending_rates.pop_front();
        end else begin
          s_tvalid <= 1'b0;
        end
      end else if (!s_tvalid) begin
        if (gap > 0) gap = gap - 1;
        else if (pending_rates.size() > 0 && !send_pause) begin
          s_tvalid <= 1'b1;
          s_tdata <= pending_rates.pop_front();
        end
      end
    end
  end

  // Monitor: checks each result transaction against the oldest expectation
  int rgap = 0;
  rate_result_t got;
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_tvalid && m_tready) begin
        got = m_tdata;
        if (expected_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result %h", m_tdata);
        end else if (got !== expected_results[0]) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp rate %0d code %h filt %h, got rate %0d code %h filt %h",
                     expected_results[0].rate, expected_results[0].code,
                     expected_results[0].filt, got.rate, got.code, got.filt);
          void'(expected_results.pop_front());
        end else begin
          void'(expected_results.pop_front());
        end
        rgap = $urandom_range(0, 5);
      end
      if (stall_hold) m_tready <= 1'b0;
      else if (rgap > 0) begin
        rgap = rgap - 1;
        m_tready <= 1'b0;
      end else m_tready <= 1'b1;
    end
  end

  // Watchdog on cycles without any transaction
  always @(posedge clk_i) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
      idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 5000) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  task automatic wait_drained();
    while (pending_rates.size() > 0 || s_tvalid || expected_results.size() > 0)
      @(posedge clk_i);
    repeat (50) @(posedge clk_i);
  endtask

  task automatic write_mode(logic m);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= m;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    precise_mode = m;
    cfg_valid_i <= 1'b0;
  endtask

  function automatic logic [23:0] rand_rate();
    int sel;
    sel = $urandom_range(0, 9);
    if (sel == 0) return 24'($urandom_range(0, 24'hFFFFFF));
    if (sel == 1) return 24'($urandom_range(0, 4100));
    if (sel == 2) return 24'($urandom_range(21900, 22100));
    if (sel == 3) return 24'($urandom_range(47900, 70000));
    return 24'($urandom_range(3990, 48010));
  endfunction

  task automatic load_directed();
    logic [23:0] vals[$];
    vals = '{24'd0, 24'd1, 24'd3999, 24'd4000, 24'd4001, 24'd8000, 24'd11025,
             24'd16000, 24'd21999, 24'd22000, 24'd22001, 24'd22050, 24'd32000,
             24'd44100, 24'd47999, 24'd48000, 24'd48001, 24'hFFFFFF, 24'h800000,
             24'h555555, 24'hAAAAAA};
    foreach (vals[i]) pending_rates.push_back(vals[i]);
  endtask

  int k;
  initial begin
    precise_mode = 1'b0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    // Legacy mode directed, then precise directed
    load_directed();
    wait_drained();
    write_mode(1'b1);
    load_directed();
    wait_drained();
    // Receiver holds off while the sender keeps offering
    stall_hold = 1'b1;
    for (k = 0; k < 80; k++) pending_rates.push_back(rand_rate());
    repeat (200) @(posedge clk_i);
    stall_hold = 1'b0;
    wait_drained();
    // Random phases across both modes
    for (int ph = 0; ph < 4; ph++) begin
      write_mode(ph[0]);
      for (k = 0; k < 200; k++) pending_rates.push_back(rand_rate());
      if (ph == 2) begin
        while (pending_rates.size() > 100) @(posedge clk_i);
        send_pause = 1'b1;
        while (s_tvalid || expected_results.size() > 0) @(posedge clk_i);
        send_pause = 1'b0;
      end
      wait_drained();
    end
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

### sim.f
+incdir+src
src/arsel_pkg.sv
src/arsel_div.sv
src/audio_rate_divider_select.sv
bench/tb_audio_rate_divider_select.sv
